### rtl/core/cartridge_bank_mapper_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank mapper
// Implication forms used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_CORE_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CBM_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cbm_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Shared types and constants for the mapper core and its interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int ROM_BYTES_W = 24;
  localparam int ROM_ADDR_W = 23;
  localparam int ROM_BANK_W = 9;
  localparam int RAM_BANK_W = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ROM_BYTES_W;
  localparam logic [CFG_IDX_W-1:0] CFG_CART_TYPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_ROM_OFF = 2'd2;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic [7:0]             hdr_type;
    logic [ROM_BYTES_W-1:0] rom_bytes;
    logic                   boot_rom_off;
  } cbm_cfg_t;

  typedef struct packed {
    logic [ROM_BANK_W-1:0] prg_bank;
    logic [RAM_BANK_W-1:0] sram_bank;
    logic                  ram_enable;
    logic                  banking_mode;
    logic                  clock_latch;
  } cbm_state_t;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } cbm_req_t;

  typedef struct packed {
    logic                  rom_hit;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic                  ram_enabled_flag;
    logic [ROM_BANK_W-1:0] rom_bank_now;
    logic [RAM_BANK_W-1:0] ram_bank_now;
    logic                  rtc_latched_flag;
  } cbm_rsp_t;

endpackage

`default_nettype wire

### rtl/core/cbm_if.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper channels
// Valid/ready channels for bus accesses in and mapping results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbm_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [cbm_pkg::ADDR_W-1:0]  address;
  logic [cbm_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, req_type, address, write_data, input ready);
  modport sink   (input valid, req_type, address, write_data, output ready);
endinterface

interface cbm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            rom_hit;
  logic [cbm_pkg::ROM_ADDR_W-1:0]  rom_address;
  logic                            ram_enabled_flag;
  logic [cbm_pkg::ROM_BANK_W-1:0]  rom_bank_now;
  logic [cbm_pkg::RAM_BANK_W-1:0]  ram_bank_now;
  logic                            rtc_latched_flag;

  modport source (output valid, rom_hit, rom_address, ram_enabled_flag, rom_bank_now,
                  ram_bank_now, rtc_latched_flag, input ready);
  modport sink   (input valid, rom_hit, rom_address, ram_enabled_flag, rom_bank_now,
                  ram_bank_now, rtc_latched_flag, output ready);
endinterface

`default_nettype wire

### rtl/core/cbm_map.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper decode
// Mapper kind decode, ROM read mapping and controller register updates.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_map (
  input  cbm_pkg::cbm_cfg_t   cfg,
  input  cbm_pkg::cbm_state_t st,
  input  cbm_pkg::cbm_req_t   req,
  output cbm_pkg::cbm_state_t st_next,
  output cbm_pkg::cbm_rsp_t   rsp
);
  import cbm_pkg::*;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_MBC1 = 3'd1;
  localparam logic [2:0] KIND_MBC2 = 3'd2;
  localparam logic [2:0] KIND_MBC3 = 3'd3;
  localparam logic [2:0] KIND_MBC5 = 3'd5;

  // write regions below 0x8000, by address bits 14:13
  localparam logic [1:0] REGION_ENABLE  = 2'd0;
  localparam logic [1:0] REGION_BANK_LO = 2'd1;
  localparam logic [1:0] REGION_BANK_HI = 2'd2;
  localparam logic [1:0] REGION_MODE    = 2'd3;

  localparam logic [ROM_BYTES_W-1:0] HEADER_LAST = 24'h000147;

  logic [2:0]            kind;
  logic [ROM_BANK_W-1:0] bank;
  logic [ROM_ADDR_W-1:0] phys;
  logic [ROM_ADDR_W-1:0] where;
  logic                  hit;
  logic [4:0]            bank5;
  logic [6:0]            bank7;
  logic [3:0]            bank4;
  logic [DATA_W-1:0]     d;

  assign d = req.write_data;

  always_comb begin
    if (cfg.rom_bytes <= HEADER_LAST) begin
      kind = KIND_NONE;
    end else begin
      case (cfg.hdr_type)
        8'h01, 8'h02, 8'h03:                      kind = KIND_MBC1;
        8'h05, 8'h06:                             kind = KIND_MBC2;
        8'h0F, 8'h10, 8'h11, 8'h12, 8'h13:        kind = KIND_MBC3;
        8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E: kind = KIND_MBC5;
        default:                                  kind = KIND_NONE;
      endcase
    end
  end

  // read mapping
  always_comb begin
    bank = st.prg_bank;
    if (kind == KIND_MBC1) begin
      bank = {2'b00, st.prg_bank[6:0]};
    end
    if (kind != KIND_MBC5 && bank == '0) begin
      bank = 9'd1;
    end
    phys  = {bank, req.address[13:0]};
    hit   = 1'b0;
    where = '0;
    if (req.req_type == REQ_READ &&
        !(req.address < 16'h0100 && !cfg.boot_rom_off)) begin
      if (req.address < 16'h4000) begin
        if ({8'h00, req.address} < cfg.rom_bytes) begin
          hit   = 1'b1;
          where = {7'd0, req.address};
        end
      end else if (req.address < 16'h8000) begin
        if ({1'b0, phys} < cfg.rom_bytes) begin
          hit   = 1'b1;
          where = phys;
        end
      end
    end
  end

  // controller register writes
  always_comb begin
    st_next = st;
    bank5   = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
    bank7   = (d[6:0] == 7'd0) ? 7'd1 : d[6:0];
    bank4   = (d[3:0] == 4'd0) ? 4'd1 : d[3:0];
    if (req.req_type == REQ_WRITE && !req.address[15] && cfg.rom_bytes != '0) begin
      case (kind)
        KIND_MBC1: begin
          case (req.address[14:13])
            REGION_ENABLE:  st_next.ram_enable = (d[3:0] == 4'hA);
            REGION_BANK_LO: st_next.prg_bank = {2'b00, st.prg_bank[6:5], bank5};
            REGION_BANK_HI: st_next.prg_bank = {2'b00, d[1:0], st.prg_bank[4:0]};
            REGION_MODE:    st_next.banking_mode = d[0];
            default: ;
          endcase
        end
        KIND_MBC2: begin
          // drop writes with address bit 8 set
          if (!req.address[8]) begin
            case (req.address[14:13])
              REGION_ENABLE:  st_next.ram_enable = (d[3:0] == 4'hA);
              REGION_BANK_LO: st_next.prg_bank = {5'd0, bank4};
              default: ;
            endcase
          end
        end
        KIND_MBC3: begin
          case (req.address[14:13])
            REGION_ENABLE:  st_next.ram_enable = (d[3:0] == 4'hA);
            REGION_BANK_LO: st_next.prg_bank = {2'b00, bank7};
            REGION_BANK_HI: begin
              // clock register selects pass through whole
              if (d >= 8'h08 && d <= 8'h0C) begin
                st_next.sram_bank = d[3:0];
              end else begin
                st_next.sram_bank = {2'b00, d[1:0]};
              end
            end
            REGION_MODE: begin
              if (d == 8'h00 && !st.clock_latch) begin
                st_next.clock_latch = 1'b1;
              end else if (d == 8'h01) begin
                st_next.clock_latch = 1'b0;
              end
            end
            default: ;
          endcase
        end
        KIND_MBC5: begin
          case (req.address[14:13])
            REGION_ENABLE: st_next.ram_enable = (d[3:0] == 4'hA);
            REGION_BANK_LO: begin
              if (!req.address[12]) begin
                st_next.prg_bank = {st.prg_bank[8], d};
              end else begin
                st_next.prg_bank = {d[0], st.prg_bank[7:0]};
              end
            end
            REGION_BANK_HI: st_next.sram_bank = d[3:0];
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rsp.rom_hit          = hit;
    rsp.rom_address      = where;
    rsp.ram_enabled_flag = st_next.ram_enable;
    rsp.rom_bank_now     = st_next.prg_bank;
    rsp.ram_bank_now     = st_next.sram_bank;
    rsp.rtc_latched_flag = st_next.clock_latch;
  end

endmodule

`default_nettype wire

### rtl/core/cartridge_bank_mapper_core.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper core
// Maps cartridge bus accesses to ROM byte addresses and tracks the bank
// controller registers.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      payload
//   -------  ---  -------------  ------------------------------------------
//   req      in   valid/ready    req_type, address, write_data
//   rsp      out  valid/ready    rom_hit, rom_address, ram_enabled_flag,
//                                rom_bank_now, ram_bank_now, rtc_latched_flag
//   cfg      in   cfg_we         cfg_index, cfg_wdata (no read-back)
//
// One transaction per cycle sustained while the result channel is not stalled; a
// result passes through the input register, then the result register, before it is valid.
// Controller registers update as a transaction moves into the result register,
// so the next request always sees them.
// Synchronous reset clears configuration and both valids and returns the bank
// registers to their reset values (ROM bank 1, everything else zero).
// A stalled result holds the result register; the input register, if empty, still
// takes one more request before req.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_mapper_core (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire [cbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [cbm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  cbm_req_if.sink                           req,
  cbm_rsp_if.source                         rsp
);
  import cbm_pkg::*;

  cbm_cfg_t   cfg;
  cbm_state_t st;
  cbm_state_t st_next;
  cbm_req_t   s1_req;
  logic       s1_valid;
  cbm_rsp_t   map_rsp;
  cbm_rsp_t   rsp_data;
  logic       rsp_valid;
  logic       s1_move;

  assign s1_move   = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CART_TYPE:    cfg.hdr_type     <= cfg_wdata[7:0];
        CFG_ROM_BYTES:    cfg.rom_bytes    <= cfg_wdata[ROM_BYTES_W-1:0];
        CFG_BOOT_ROM_OFF: cfg.boot_rom_off <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req <= '{req_type: req.req_type, address: req.address,
                  write_data: req.write_data};
    end
  end

  cbm_map u_map (
    .cfg     (cfg),
    .st      (st),
    .req     (s1_req),
    .st_next (st_next),
    .rsp     (map_rsp)
  );

  // controller registers advance with each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{prg_bank: 9'd1, sram_bank: '0, ram_enable: 1'b0,
              banking_mode: 1'b0, clock_latch: 1'b0};
    end else if (s1_move) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp_data <= map_rsp;
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.rom_hit          = rsp_data.rom_hit;
  assign rsp.rom_address      = rsp_data.rom_address;
  assign rsp.ram_enabled_flag = rsp_data.ram_enabled_flag;
  assign rsp.rom_bank_now     = rsp_data.rom_bank_now;
  assign rsp.ram_bank_now     = rsp_data.ram_bank_now;
  assign rsp.rtc_latched_flag = rsp_data.rtc_latched_flag;

endmodule

`default_nettype wire

### rtl/core/cbm_checker.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cartridge_bank_mapper_core_assert.svh"

module cbm_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               rsp_valid,
  input wire                               rsp_ready,
  input wire                               rom_hit,
  input wire [cbm_pkg::ROM_ADDR_W-1:0]     rom_address,
  input wire                               ram_enabled_flag,
  input wire [cbm_pkg::ROM_BANK_W-1:0]     rom_bank_now,
  input wire [cbm_pkg::RAM_BANK_W-1:0]     ram_bank_now,
  input wire                               rtc_latched_flag
);
  import cbm_pkg::*;

  logic [$bits(cbm_rsp_t)-1:0] payload;

  assign payload = {rom_hit, rom_address, ram_enabled_flag, rom_bank_now,
                    ram_bank_now, rtc_latched_flag};

  `CBM_ASSERT_NEXT(a_rsp_valid_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
  `CBM_ASSERT_NEXT(a_rsp_payload_hold, clk, rst, rsp_valid && !rsp_ready, $stable(payload), "result changed while stalled")
  `CBM_ASSERT_NOW(a_miss_zero_addr, clk, rst, rsp_valid && !rom_hit, rom_address == '0, "miss with non-zero ROM address")
  `CBM_ASSERT_NOW(a_idle_after_reset, clk, rst, $past(rst), !rsp_valid, "result pending straight after reset")

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rom_hit          (rsp.rom_hit),
  .rom_address      (rsp.rom_address),
  .ram_enabled_flag (rsp.ram_enabled_flag),
  .rom_bank_now     (rsp.rom_bank_now),
  .ram_bank_now     (rsp.ram_bank_now),
  .rtc_latched_flag (rsp.rtc_latched_flag)
);

`default_nettype wire

### verif/tb_cartridge_bank_mapper_core.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper core testbench
// Drives bus accesses through a table of directed cases and then random
// phases under changing mapper settings. A behavioural copy of the bank
// controller predicts each result not fixed in the table; each is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cartridge_bank_mapper_core;
  import cbm_pkg::*;

  localparam int BANK_BYTES  = 16384;
  localparam int IDLE_PCT    = 31;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 110;
  localparam int CALM_PHASE  = 6;

  typedef enum logic [2:0] {MAP_NONE, MAP_MBC1, MAP_MBC2, MAP_MBC3, MAP_MBC5} map_kind_t;

  typedef struct {
    bit                    is_reg_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    cbm_req_t              access;
    bit                    has_fixed;
    cbm_rsp_t              fixed_result;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cbm_req_if req_ch ();
  cbm_rsp_if rsp_ch ();

  cartridge_bank_mapper_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #10 clk = ~clk;

  cbm_cfg_t   mapper_cfg;
  cbm_state_t bank_regs;
  cbm_rsp_t   pending_results[$];
  int         mismatch_count = 0;
  bit         calm = 1'b0;

  // Directed table of register writes and bus accesses: typed results where they are obvious.
  plan_row_t directed_plan [35] = '{
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_READ,  16'h0000, 8'h00}, 1'b1,
      {1'b0, 23'h0, 1'b0, 9'h001, 4'h0, 1'b0}},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h2000, 8'h05}, 1'b1,
      {1'b0, 23'h0, 1'b0, 9'h001, 4'h0, 1'b0}},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_READ,  16'h4000, 8'h00}, 1'b1,
      {1'b0, 23'h0, 1'b0, 9'h001, 4'h0, 1'b0}},
    '{1'b1, CFG_ROM_BYTES,    24'h800000, '0, 1'b0, '0},
    '{1'b1, CFG_CART_TYPE,    24'h000001, '0, 1'b0, '0},
    '{1'b1, CFG_BOOT_ROM_OFF, 24'h000001, '0, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_READ,  16'h0000, 8'h00}, 1'b1,
      {1'b1, 23'h0, 1'b0, 9'h001, 4'h0, 1'b0}},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_READ,  16'h3FFF, 8'hFF}, 1'b1,
      {1'b1, 23'h3FFF, 1'b0, 9'h001, 4'h0, 1'b0}},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h0000, 8'h0A}, 1'b1,
      {1'b0, 23'h0, 1'b1, 9'h001, 4'h0, 1'b0}},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h2000, 8'h00}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h3FFF, 8'hFF}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h4000, 8'h03}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_READ,  16'h7FFF, 8'h00}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h6000, 8'h01}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_READ,  16'h8000, 8'h00}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'hA000, 8'hFF}, 1'b0, '0},
    '{1'b1, CFG_CART_TYPE,    24'h000005, '0, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h2100, 8'h03}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h2000, 8'h00}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h0000, 8'h00}, 1'b0, '0},
    '{1'b1, CFG_CART_TYPE,    24'h000013, '0, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h4000, 8'h0C}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h5FFF, 8'h0D}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h6000, 8'h00}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h7FFF, 8'h00}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h6000, 8'h01}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h2000, 8'h80}, 1'b0, '0},
    '{1'b1, CFG_CART_TYPE,    24'h00001E, '0, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h2000, 8'h00}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_READ,  16'h4000, 8'h00}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h3000, 8'hFF}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_READ,  16'h7FFF, 8'h00}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_WRITE, 16'h4000, 8'hFF}, 1'b0, '0},
    '{1'b1, CFG_ROM_BYTES,    24'h000147, '0, 1'b0, '0},
    '{1'b1, CFG_BOOT_ROM_OFF, 24'h000000, '0, 1'b0, '0}
  };

  // Two overlay reads close the table once the header has dropped out of range.
  plan_row_t overlay_plan [2] = '{
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_READ, 16'h00FF, 8'h00}, 1'b0, '0},
    '{1'b0, CFG_CART_TYPE, 24'h0, {REQ_READ, 16'h0100, 8'h00}, 1'b0, '0}
  };

  function automatic map_kind_t decode_kind(cbm_cfg_t c);
    if (c.rom_bytes <= 24'h147) return MAP_NONE;
    case (c.hdr_type)
      8'h01, 8'h02, 8'h03:                      return MAP_MBC1;
      8'h05, 8'h06:                             return MAP_MBC2;
      8'h0F, 8'h10, 8'h11, 8'h12, 8'h13:        return MAP_MBC3;
      8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E: return MAP_MBC5;
      default:                                  return MAP_NONE;
    endcase
  endfunction

  // Apply one bus access to the mirrored controller and return its result.
  function automatic cbm_rsp_t map_access(cbm_req_t r);
    cbm_rsp_t    res;
    map_kind_t   kind;
    logic [15:0] a;
    logic [7:0]  d;
    int unsigned bank;
    int unsigned phys;
    res  = '0;
    kind = decode_kind(mapper_cfg);
    a    = r.address;
    d    = r.write_data;
    if (r.req_type == REQ_WRITE) begin
      if (a < 16'h8000 && mapper_cfg.rom_bytes != '0) begin
        case (kind)
          MAP_MBC1: begin
            if (a < 16'h2000) begin
              bank_regs.ram_enable = (d[3:0] == 4'hA);
            end else if (a < 16'h4000) begin
              bank_regs.prg_bank = {2'b00, bank_regs.prg_bank[6:5],
                                    (d[4:0] == 5'd0) ? 5'd1 : d[4:0]};
            end else if (a < 16'h6000) begin
              bank_regs.prg_bank = {2'b00, d[1:0], bank_regs.prg_bank[4:0]};
            end else begin
              bank_regs.banking_mode = d[0];
            end
          end
          MAP_MBC2: begin
            if (!a[8]) begin
              if (a < 16'h2000) bank_regs.ram_enable = (d[3:0] == 4'hA);
              else if (a < 16'h4000)
                bank_regs.prg_bank = (d[3:0] == 4'd0) ? 9'd1 : {5'd0, d[3:0]};
            end
          end
          MAP_MBC3: begin
            if (a < 16'h2000) begin
              bank_regs.ram_enable = (d[3:0] == 4'hA);
            end else if (a < 16'h4000) begin
              bank_regs.prg_bank = (d[6:0] == 7'd0) ? 9'd1 : {2'b00, d[6:0]};
            end else if (a < 16'h6000) begin
              bank_regs.sram_bank = (d >= 8'h08 && d <= 8'h0C) ? d[3:0]
                                                               : {2'b00, d[1:0]};
            end else begin
              if (d == 8'h00 && !bank_regs.clock_latch) bank_regs.clock_latch = 1'b1;
              else if (d == 8'h01) bank_regs.clock_latch = 1'b0;
            end
          end
          MAP_MBC5: begin
            if (a < 16'h2000) bank_regs.ram_enable = (d[3:0] == 4'hA);
            else if (a < 16'h3000) bank_regs.prg_bank = {bank_regs.prg_bank[8], d};
            else if (a < 16'h4000) bank_regs.prg_bank = {d[0], bank_regs.prg_bank[7:0]};
            else if (a < 16'h6000) bank_regs.sram_bank = d[3:0];
          end
          default: ;
        endcase
      end
    end else if (!(a < 16'h0100 && !mapper_cfg.boot_rom_off)) begin
      if (a < 16'h4000) begin
        if ({8'h00, a} < mapper_cfg.rom_bytes) begin
          res.rom_hit     = 1'b1;
          res.rom_address = {7'd0, a};
        end
      end else if (a < 16'h8000) begin
        bank = 32'(bank_regs.prg_bank);
        if (kind == MAP_MBC1) bank = bank & 32'h7F;
        if (kind != MAP_MBC5 && bank == 0) bank = 1;
        phys = bank * BANK_BYTES + (32'(a) - 32'h4000);
        if (phys < 32'(mapper_cfg.rom_bytes)) begin
          res.rom_hit     = 1'b1;
          res.rom_address = phys[22:0];
        end
      end
    end
    res.ram_enabled_flag = bank_regs.ram_enable;
    res.rom_bank_now     = bank_regs.prg_bank;
    res.ram_bank_now     = bank_regs.sram_bank;
    res.rtc_latched_flag = bank_regs.clock_latch;
    return res;
  endfunction

  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Mostly well-formed controller traffic, with some bus noise mixed in.
  function automatic cbm_req_t gen_access();
    cbm_req_t    r;
    int unsigned sel;
    sel          = $urandom_range(99);
    r.req_type   = 1'($urandom_range(1));
    r.address    = 16'($urandom_range(16'hFFFF));
    r.write_data = 8'($urandom_range(8'hFF));
    if (sel < 40) begin
      r.req_type = REQ_READ;
      r.address  = ($urandom_range(7) == 0) ? 16'($urandom_range(16'h00FF))
                                            : 16'($urandom_range(16'h7FFF));
    end else if (sel < 80) begin
      r.req_type = REQ_WRITE;
      r.address  = 16'($urandom_range(16'h7FFF));
      case ($urandom_range(7))
        0:       r.write_data = {4'($urandom_range(15)), 4'hA};
        1:       r.write_data = 8'h00;
        2:       r.write_data = 8'h01;
        3:       r.write_data = 8'($urandom_range(8'h0C, 8'h08));
        4:       r.write_data = 8'($urandom_range(31));
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CART_TYPE:    mapper_cfg.hdr_type     = val[7:0];
      CFG_ROM_BYTES:    mapper_cfg.rom_bytes    = val;
      CFG_BOOT_ROM_OFF: mapper_cfg.boot_rom_off = val[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold requests until every outstanding result has been taken.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_access(input cbm_req_t r, input bit has_fixed, input cbm_rsp_t fixed);
    cbm_rsp_t predicted;
    while (take_gap()) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.req_type;
    req_ch.address    <= r.address;
    req_ch.write_data <= r.write_data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = map_access(r);
    pending_results.push_back(has_fixed ? fixed : predicted);
  endtask

  task automatic run_row(input plan_row_t row);
    if (row.is_reg_write) begin
      wait_idle();
      write_reg(row.reg_idx, row.reg_val);
    end else begin
      send_access(row.access, row.has_fixed, row.fixed_result);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    cbm_rsp_t got;
    cbm_rsp_t want;
    got = {rsp_ch.rom_hit, rsp_ch.rom_address, rsp_ch.ram_enabled_flag,
           rsp_ch.rom_bank_now, rsp_ch.ram_bank_now, rsp_ch.rtc_latched_flag};
    if (pending_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: result with no access outstanding, expected none, actual %h",
               $time, got);
      return;
    end
    want = pending_results.pop_front();
    compare_field("rom_hit",          32'(want.rom_hit),          32'(got.rom_hit));
    compare_field("rom_address",      32'(want.rom_address),      32'(got.rom_address));
    compare_field("ram_enabled_flag", 32'(want.ram_enabled_flag),
                  32'(got.ram_enabled_flag));
    compare_field("rom_bank_now",     32'(want.rom_bank_now),     32'(got.rom_bank_now));
    compare_field("ram_bank_now",     32'(want.ram_bank_now),     32'(got.ram_bank_now));
    compare_field("rtc_latched_flag", 32'(want.rtc_latched_flag),
                  32'(got.rtc_latched_flag));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) check_result();
      rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [7:0] pick_hdr_type(int p);
    case (p % 6)
      0:       return 8'($urandom_range(8'h03, 8'h01));
      1:       return 8'($urandom_range(8'h06, 8'h05));
      2:       return 8'($urandom_range(8'h13, 8'h0F));
      3:       return 8'($urandom_range(8'h1E, 8'h19));
      4:       return 8'($urandom_range(8'hFF));
      default: return ((p / 6) % 2 == 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rom_bytes(int p);
    if (p == 0) return 24'h800000;
    if (p == 1) return 24'h000000;
    if (p == 2) return 24'h000148;
    case ($urandom_range(5))
      0, 1:    return 24'h800000;
      2:       return 24'($urandom_range(24'h800000));
      3:       return 24'($urandom_range(24'h000147));
      default: return 24'($urandom_range(512, 1) * BANK_BYTES);
    endcase
  endfunction

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_CART_TYPE;
    cfg_wdata         <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_READ;
    req_ch.address    <= '0;
    req_ch.write_data <= '0;
    mapper_cfg         = '0;
    bank_regs          = '0;
    bank_regs.prg_bank = 9'd1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) run_row(directed_plan[i]);
    foreach (overlay_plan[i]) run_row(overlay_plan[i]);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_CART_TYPE, {16'd0, pick_hdr_type(p)});
      write_reg(CFG_ROM_BYTES, pick_rom_bytes(p));
      write_reg(CFG_BOOT_ROM_OFF, (p < 2) ? 24'(p) : 24'($urandom_range(1)));
      calm = (p == CALM_PHASE);
      for (int i = 0; i < PHASE_ITEMS; i++) send_access(gen_access(), 1'b0, '0);
    end
    calm = 1'b0;

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
